// ----- hdl/hlse_pkg.sv -----
`default_nettype none

package hlse_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CHAR = 1'b1;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_PASS = 2'd1,
        K_SLOT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [7:0] pay;
        logic [3:0] val;
        logic       bad;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       bit_slot;
        logic       load_refused;
        logic       payload_done;
        logic       starved;
        logic       bad_digit;
        logic       got_valid;
        logic [7:0] got_byte;
        logic       line_end;
    } t_result;

    // {bad, value}; a non-hex character reads as value 0xF
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] r;
        r = {1'b1, 4'hF};
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            r = {1'b0, 4'(ch - CH_ZERO)};
        end else if (ch >= CH_LA && ch <= CH_LF) begin
            r = {1'b0, 4'(ch - CH_LA + 8'd10)};
        end else if (ch >= CH_UA && ch <= CH_UF) begin
            r = {1'b0, 4'(ch - CH_UA + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'h0, v};
        end else begin
            r = CH_LA + {4'h0, v} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_NL) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/hlse_front.sv -----
`default_nettype none

module hlse_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  wire              i_opcode,
    input  wire  [7:0]       i_char,
    input  wire  [7:0]       i_pay,
    output hlse_pkg::t_cmd   o_cmd
);
    import hlse_pkg::*;

    logic       r_pair_phase;
    logic       n_pair_phase;
    logic [4:0] hv;

    assign hv = hex_value(i_char);

    always_comb begin
        n_pair_phase = r_pair_phase;
        o_cmd.ch     = i_char;
        o_cmd.pay    = i_pay;
        o_cmd.val    = hv[3:0];
        o_cmd.bad    = hv[4];
        if (i_opcode == OP_LOAD) begin
            o_cmd.kind = K_LOAD;
        end else if (is_space(i_char)) begin
            o_cmd.kind = K_PASS;
        end else if (!r_pair_phase) begin
            o_cmd.kind   = K_PASS;
            n_pair_phase = 1'b1;
        end else begin
            o_cmd.kind   = K_SLOT;
            n_pair_phase = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_phase <= 1'b0;
        end else if (i_accept) begin
            r_pair_phase <= n_pair_phase;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hlse_queue.sv -----
`default_nettype none

module hlse_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire  hlse_pkg::t_cmd   i_cmd,
    output logic                   o_full,
    input  wire                    i_pop,
    output logic                   o_valid,
    output hlse_pkg::t_cmd         o_cmd
);
    import hlse_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hlse_back.sv -----
`default_nettype none

module hlse_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_wdata,
    input  wire                i_cmd_valid,
    input  wire hlse_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_stall,
    output hlse_pkg::t_result  o_res
);
    import hlse_pkg::*;

    logic       r_mode;
    logic [2:0] r_bit_pos;
    logic [2:0] n_bit_pos;
    logic [7:0] r_shift;
    logic [7:0] n_shift;
    logic       r_pending;
    logic       n_pending;
    logic [7:0] r_gather;
    logic [7:0] n_gather;
    logic       r_valid;
    t_result    r_res;
    t_result    n_res;

    assign o_pop   = i_cmd_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_bit_pos = r_bit_pos;
        n_shift   = r_shift;
        n_pending = r_pending;
        n_gather  = r_gather;
        n_res     = '0;
        unique case (i_cmd.kind)
            K_LOAD: begin
                if (r_mode == MODE_EMBED) begin
                    if (r_pending) begin
                        n_res.load_refused = 1'b1;
                    end else begin
                        n_shift   = i_cmd.pay;
                        n_pending = 1'b1;
                        n_bit_pos = 3'd0;
                    end
                end
            end
            K_PASS: begin
                n_res.out_char   = i_cmd.ch;
                n_res.char_valid = 1'b1;
            end
            K_SLOT: begin
                n_res.out_char   = i_cmd.ch;
                n_res.char_valid = 1'b1;
                n_res.bit_slot   = 1'b1;
                n_res.bad_digit  = i_cmd.bad;
                n_bit_pos        = r_bit_pos + 3'd1;
                if (r_mode == MODE_EMBED) begin
                    if (!r_pending) begin
                        n_res.starved = 1'b1;
                        n_bit_pos     = r_bit_pos;
                    end else begin
                        n_shift        = {r_shift[6:0], 1'b0};
                        n_res.out_char = i_cmd.bad ? CH_X
                                       : hex_digit({i_cmd.val[3:1], r_shift[7]});
                        if (r_bit_pos == 3'd7) begin
                            n_res.payload_done = 1'b1;
                            n_pending          = 1'b0;
                        end
                    end
                end else begin
                    n_gather = {r_gather[6:0], i_cmd.val[0]};
                    if (r_bit_pos == 3'd7) begin
                        n_res.got_valid = 1'b1;
                        n_res.got_byte  = n_gather;
                        n_res.line_end  = (n_gather == CH_NL);
                        n_gather        = 8'h00;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_EMBED;
            r_bit_pos <= 3'd0;
            r_shift   <= 8'h00;
            r_pending <= 1'b0;
            r_gather  <= 8'h00;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode    <= i_cfg_wdata;
                r_bit_pos <= 3'd0;
                r_shift   <= 8'h00;
                r_pending <= 1'b0;
                r_gather  <= 8'h00;
            end else if (o_pop) begin
                r_bit_pos <= n_bit_pos;
                r_shift   <= n_shift;
                r_pending <= n_pending;
                r_gather  <= n_gather;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hex_lsb_stego_embed_extract_core.sv -----
// Hex-text LSB embed/extract core. Items are either payload-byte loads
// (opcode 0) or carrier characters (opcode 1); every accepted item yields
// exactly one result item. Whitespace passes through; the second non-space
// character of each pair carries one hidden bit. Throughput is one item per
// clock while the output is not stalled: the front classifier feeds a
// two-entry queue, and the back end updates the bit state and registers the
// result. Write the mode register only while the core is idle; a write
// clears the bit state but keeps the pair phase.
`default_nettype none

module hex_lsb_stego_embed_extract_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_opcode,
    input  wire  [7:0] i_carrier_char,
    input  wire  [7:0] i_payload_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_bit_slot,
    output logic       o_load_refused,
    output logic       o_payload_done,
    output logic       o_starved,
    output logic       o_bad_digit,
    output logic       o_got_valid,
    output logic [7:0] o_got_byte,
    output logic       o_line_end
);
    import hlse_pkg::*;

    logic    accept;
    logic    q_full;
    logic    q_valid;
    logic    pop;
    t_cmd    f_cmd;
    t_cmd    q_cmd;
    t_result res;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    hlse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_opcode(i_opcode),
        .i_char  (i_carrier_char),
        .i_pay   (i_payload_byte),
        .o_cmd   (f_cmd)
    );

    hlse_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_cmd  (f_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    hlse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (res)
    );

    assign o_out_char     = res.out_char;
    assign o_char_valid   = res.char_valid;
    assign o_bit_slot     = res.bit_slot;
    assign o_load_refused = res.load_refused;
    assign o_payload_done = res.payload_done;
    assign o_starved      = res.starved;
    assign o_bad_digit    = res.bad_digit;
    assign o_got_valid    = res.got_valid;
    assign o_got_byte     = res.got_byte;
    assign o_line_end     = res.line_end;

endmodule

`default_nettype wire

// ----- hdl/hlse_checker.sv -----
`default_nettype none

module hlse_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire [7:0] o_out_char,
    input wire       o_char_valid,
    input wire       o_bit_slot,
    input wire       o_payload_done,
    input wire       o_starved,
    input wire       o_got_valid,
    input wire [7:0] o_got_byte,
    input wire       o_line_end
);
    import hlse_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid |-> !o_bit_slot && o_out_char == 8'h00)
        else $error("load result carries character data");

    a_got_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_got_valid |-> o_bit_slot && o_char_valid)
        else $error("byte completed outside a bit slot");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_done |-> o_bit_slot && !o_starved && !o_got_valid)
        else $error("payload done on a non-embedding slot");

    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> o_got_valid && o_got_byte == CH_NL)
        else $error("line end without a newline byte");

endmodule

bind hex_lsb_stego_embed_extract_core hlse_checker u_hlse_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
    import hlse_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_opcode = 1'b0;
    logic [7:0] i_carrier_char = 8'h00;
    logic [7:0] i_payload_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_bit_slot;
    logic       o_load_refused;
    logic       o_payload_done;
    logic       o_starved;
    logic       o_bad_digit;
    logic       o_got_valid;
    logic [7:0] o_got_byte;
    logic       o_line_end;

    hex_lsb_stego_embed_extract_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_carrier_char (i_carrier_char),
        .i_payload_byte (i_payload_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_bit_slot     (o_bit_slot),
        .o_load_refused (o_load_refused),
        .o_payload_done (o_payload_done),
        .o_starved      (o_starved),
        .o_bad_digit    (o_bad_digit),
        .o_got_valid    (o_got_valid),
        .o_got_byte     (o_got_byte),
        .o_line_end     (o_line_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stego state mirror
    logic       mode_q   = MODE_EMBED;
    logic       pair_q   = 1'b0;
    logic [2:0] bits_q   = 3'd0;
    logic [7:0] shift_q  = 8'h00;
    logic       pend_q   = 1'b0;
    logic [7:0] gather_q = 8'h00;

    t_result expected_results[$];
    t_result last_res;

    int  mismatches = 0;
    int  n_items = 0;
    int  n_loads = 0;
    int  n_refused = 0;
    int  n_done = 0;
    int  n_starved = 0;
    int  n_got = 0;
    int  n_line = 0;
    int  n_writes = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  rx_hold;
    int  rx_left = 0;
    int  quiet_cycles = 0;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_NL || c == CH_TAB || c == CH_CR || c == CH_SPACE;
    endfunction

    // {not_hex, nibble}; non-hex reads as 0xF
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return {1'b0, c[3:0]};
        end
        if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h1F;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return CH_ZERO + 8'(v);
        end
        return (upper ? CH_UA : CH_LA) + 8'(v) - 8'd10;
    endfunction

    function automatic t_result predict(input logic op, input logic [7:0] ch,
                                        input logic [7:0] pay);
        t_result r;
        logic [4:0] nib;
        logic b;
        r = '0;
        if (op == OP_LOAD) begin
            if (mode_q == MODE_EMBED) begin
                if (pend_q) begin
                    r.load_refused = 1'b1;
                end else begin
                    shift_q = pay;
                    pend_q = 1'b1;
                    bits_q = 3'd0;
                end
            end
            return r;
        end
        r.out_char = ch;
        r.char_valid = 1'b1;
        if (is_blank(ch)) begin
            return r;
        end
        if (!pair_q) begin
            pair_q = 1'b1;
            return r;
        end
        pair_q = 1'b0;
        r.bit_slot = 1'b1;
        nib = nibble_of(ch);
        r.bad_digit = nib[4];
        if (mode_q == MODE_EMBED) begin
            if (!pend_q) begin
                r.starved = 1'b1;
            end else begin
                b = shift_q[7];
                shift_q = {shift_q[6:0], 1'b0};
                r.out_char = nib[4] ? CH_X : hex_char({nib[3:1], b}, 1'b0);
                bits_q = bits_q + 3'd1;
                if (bits_q == 3'd0) begin
                    r.payload_done = 1'b1;
                    pend_q = 1'b0;
                end
            end
        end else begin
            gather_q = {gather_q[6:0], nib[0]};
            bits_q = bits_q + 3'd1;
            if (bits_q == 3'd0) begin
                r.got_valid = 1'b1;
                r.got_byte = gather_q;
                r.line_end = (gather_q == CH_NL);
                gather_q = 8'h00;
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] ch, input logic [7:0] pay);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_carrier_char <= ch;
        i_payload_byte <= pay;
        do @(posedge i_clk); while (o_in_stall);
        last_res = predict(op, ch, pay);
        expected_results.push_back(last_res);
        n_items++;
        if (op == OP_LOAD) n_loads++;
        if (last_res.load_refused) n_refused++;
        if (last_res.payload_done) n_done++;
        if (last_res.starved) n_starved++;
        if (last_res.got_valid) n_got++;
        if (last_res.line_end) n_line++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_q = m;
        bits_q = 3'd0;
        shift_q = 8'h00;
        pend_q = 1'b0;
        gather_q = 8'h00;
        n_writes++;
    endtask

    task automatic pick_idling();
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
    endtask

    function automatic logic [7:0] rand_carrier();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
        if (pick < 15) begin
            case ($urandom_range(0, 3))
                0: return CH_NL;
                1: return CH_TAB;
                2: return CH_CR;
                default: return CH_SPACE;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_payload();
        if ($urandom_range(0, 7) == 0) begin
            return {8{1'($urandom_range(0, 1))}};
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // slot char whose hex lsb is b; non-hex reads as 1
    function automatic logic [7:0] slot_char(input logic b);
        logic [7:0] c;
        logic [4:0] nib;
        if (b && $urandom_range(0, 5) == 0) begin
            do begin
                c = 8'($urandom_range(0, 255));
                nib = nibble_of(c);
            end while (!nib[4] || is_blank(c));
            return c;
        end
        return hex_char({3'($urandom_range(0, 7)), b}, 1'($urandom_range(0, 1)));
    endfunction

    task automatic test_embed_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(OP_CHAR, 8'h00, 8'hFF);
        send_item(OP_CHAR, "z", 8'h00);
        send_item(OP_LOAD, 8'hFF, 8'hA5);
        send_item(OP_LOAD, 8'h00, 8'h00);
        send_item(OP_CHAR, "1", 8'h00);
        send_item(OP_CHAR, "A", 8'h00);
        send_item(OP_CHAR, CH_NL, 8'h00);
        send_item(OP_CHAR, "b", 8'h00);
        send_item(OP_CHAR, "F", 8'h00);
        send_item(OP_CHAR, CH_TAB, 8'h00);
        send_item(OP_CHAR, "c", 8'h00);
        send_item(OP_CHAR, "0", 8'h00);
        send_item(OP_CHAR, CH_CR, 8'h00);
        send_item(OP_CHAR, "d", 8'h00);
        send_item(OP_CHAR, "9", 8'h00);
        send_item(OP_CHAR, CH_SPACE, 8'h00);
        send_item(OP_CHAR, "e", 8'h00);
        send_item(OP_CHAR, "f", 8'h00);
        send_item(OP_CHAR, "2", 8'h00);
        send_item(OP_CHAR, 8'hFF, 8'h00);
        send_item(OP_CHAR, "3", 8'h00);
        send_item(OP_CHAR, "B", 8'h00);
        send_item(OP_CHAR, "4", 8'h00);
        send_item(OP_CHAR, "C", 8'h00);
    endtask

    task automatic test_extract_directed();
        write_mode(MODE_EXTRACT);
        send_item(OP_LOAD, 8'h00, 8'hFF);
        send_item(OP_CHAR, "q", 8'h00);
        send_item(OP_CHAR, "Q", 8'h00);
    endtask

    // mode write keeps the pair phase
    task automatic test_mode_keeps_pair();
        send_item(OP_CHAR, "a", 8'h00);
        write_mode(MODE_EMBED);
        send_item(OP_CHAR, "b", 8'h00);
    endtask

    task automatic test_embed_stream(input int count);
        int sent;
        write_mode(MODE_EMBED);
        sent = 0;
        while (sent < count) begin
            if (sent % 64 == 0) pick_idling();
            if (sent == count / 2) settle();
            if (!pend_q && $urandom_range(0, 4) != 0) begin
                send_item(OP_LOAD, 8'($urandom_range(0, 255)), rand_payload());
            end else if (pend_q && $urandom_range(0, 24) == 0) begin
                send_item(OP_LOAD, 8'($urandom_range(0, 255)), rand_payload());
            end else begin
                send_item(OP_CHAR, rand_carrier(), 8'($urandom_range(0, 255)));
            end
            sent++;
        end
    endtask

    task automatic test_extract_stream(input int count);
        int sent;
        logic [7:0] hidden;
        write_mode(MODE_EXTRACT);
        hidden = CH_NL;
        sent = 0;
        while (sent < count) begin
            if (sent % 64 == 0) pick_idling();
            if (sent == count / 2) settle();
            if ($urandom_range(0, 39) == 0) begin
                send_item(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                if (pair_q && $urandom_range(0, 19) != 0) begin
                    send_item(OP_CHAR, slot_char(hidden[3'd7 - bits_q]),
                              8'($urandom_range(0, 255)));
                end else begin
                    send_item(OP_CHAR, rand_carrier(), 8'($urandom_range(0, 255)));
                end
                if (last_res.got_valid) begin
                    hidden = ($urandom_range(0, 2) == 0) ? CH_NL : rand_payload();
                end
                sent++;
            end
        end
    endtask

    task automatic test_noise(input int count);
        int sent;
        logic op;
        sent = 0;
        while (sent < count) begin
            if (sent % 50 == 0) begin
                write_mode(1'($urandom_range(0, 1)));
                pick_idling();
            end
            op = 1'($urandom_range(0, 3) != 0);
            send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (op == OP_CHAR || mode_q == MODE_EMBED) sent++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %02h, got %02h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic last_res_check(input t_result want);
        check_field("out_char", want.out_char, o_out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(o_char_valid));
        check_field("bit_slot", 8'(want.bit_slot), 8'(o_bit_slot));
        check_field("load_refused", 8'(want.load_refused), 8'(o_load_refused));
        check_field("payload_done", 8'(want.payload_done), 8'(o_payload_done));
        check_field("starved", 8'(want.starved), 8'(o_starved));
        check_field("bad_digit", 8'(want.bad_digit), 8'(o_bad_digit));
        check_field("got_valid", 8'(want.got_valid), 8'(o_got_valid));
        check_field("got_byte", want.got_byte, o_got_byte);
        check_field("line_end", 8'(want.line_end), 8'(o_line_end));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result item with no expectation pending");
                mismatches++;
            end else begin
                last_res_check(expected_results.pop_front());
            end
            rx_hold = rx_idle ? $urandom_range(0, 7) : 0;
            if (rx_hold != 0) i_out_stall <= 1'b1;
            rx_left <= rx_hold;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
            if (rx_left == 1) i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_embed_directed();
        test_extract_directed();
        test_mode_keeps_pair();
        test_embed_stream(300);
        test_extract_stream(250);
        test_noise(150);
        settle();
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("Sent %0d items (%0d loads, %0d refused) over %0d mode writes.",
                 n_items, n_loads, n_refused, n_writes);
        $display("Embedded %0d bytes, %0d starved slots; extracted %0d bytes, %0d newlines.",
                 n_done, n_starved, n_got, n_line);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
